// File: rtl/drawer_poll_retry_master_assert.svh
// assertion macros shared by the drawer poll master rtl
`ifndef DRAWER_POLL_RETRY_MASTER_ASSERT_SVH
`define DRAWER_POLL_RETRY_MASTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DPRM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dprm check failed");

// next-cycle implication, checked outside reset
`define DPRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dprm check failed");

`endif

// File: rtl/dprm_pkg.sv
// package for the drawer poll master: config indexes, reset values, helpers
package dprm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_DELAY      = 3'd0,
    CFG_TX_TIMEOUT      = 3'd1,
    CFG_RESEND_INTERVAL = 3'd2,
    CFG_RETRY_INTERVAL  = 3'd3,
    CFG_RETRY_LIMIT     = 3'd4,
    CFG_READ_COMMAND    = 3'd5
  } cfg_idx_t;

  localparam logic [15:0] POLL_DELAY_RST      = 16'd1000;
  localparam logic [15:0] TX_TIMEOUT_RST      = 16'd500;
  localparam logic [15:0] RESEND_INTERVAL_RST = 16'd200;
  localparam logic [15:0] RETRY_INTERVAL_RST  = 16'd100;
  localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd3;
  localparam logic [7:0]  READ_COMMAND_RST    = 8'd5;

  // drawer addresses on the link
  localparam logic [7:0] DRAWER_A = 8'h01;
  localparam logic [7:0] DRAWER_B = 8'h03;
  localparam logic [7:0] DRAWER_C = 8'h05;
  localparam logic [7:0] DRAWER_D = 8'h07;

  localparam logic [3:0] RETRY_COUNT_MAX = 4'd15;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/drawer_poll_retry_master.sv
// drawer poll master: polls drawers 1, 3, 5, 7 with retry, skip and round delay
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | frame_valid frame_cmd frame_addr tx_done
//  out     | output    | out_valid / out_ready| send_request request_addr driver_enable
//          |           |                      | reply_addr round_done
//  cfg     | input     | cfg_wr_en            | cfg_index cfg_data
//
// one tick per clock unless the result register is full and out_ready is low:
// a transfer lands in the input register, then the tick logic updates the poll
// state and loads the result register; input register and result register each
// hold one item; in_ready drops only when both are full and out_ready is low
// synchronous active-high rst restores config defaults and clears the poll state and both valid flags
module drawer_poll_retry_master (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             frame_valid,
  input  logic [7:0]                       frame_cmd,
  input  logic [7:0]                       frame_addr,
  input  logic                             tx_done,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             send_request,
  output logic [2:0]                       request_addr,
  output logic                             driver_enable,
  output logic [7:0]                       reply_addr,
  output logic                             round_done,
  input  logic                             cfg_wr_en,
  input  logic [dprm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dprm_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "drawer_poll_retry_master_assert.svh"

  // config registers
  logic [15:0] poll_delay, tx_timeout, resend_interval, retry_interval;
  logic [3:0]  retry_limit;
  logic [7:0]  read_command;

  // poll state
  logic [7:0]  last_reply, last_reply_next;
  logic [2:0]  target, target_next;
  logic        request_pending, request_pending_next;
  logic        tx_busy, tx_busy_next;
  logic [15:0] tx_timer, tx_timer_next;
  logic [15:0] resend_timer, resend_timer_next;
  logic [15:0] retry_timer, retry_timer_next;
  logic [3:0]  retry_count, retry_count_next;
  logic [15:0] delay_counter, delay_counter_next;

  // input register
  logic        in_reg_valid;
  logic        in_frame_valid, in_tx_done;
  logic [7:0]  in_frame_cmd, in_frame_addr;
  logic        advance;

  // tick results
  logic        sent, done;
  logic [2:0]  sent_addr;
  logic        fire_resend, fire_retry, skip;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_delay      <= dprm_pkg::POLL_DELAY_RST;
      tx_timeout      <= dprm_pkg::TX_TIMEOUT_RST;
      resend_interval <= dprm_pkg::RESEND_INTERVAL_RST;
      retry_interval  <= dprm_pkg::RETRY_INTERVAL_RST;
      retry_limit     <= dprm_pkg::RETRY_LIMIT_RST;
      read_command    <= dprm_pkg::READ_COMMAND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dprm_pkg::CFG_POLL_DELAY:      poll_delay      <= cfg_data;
        dprm_pkg::CFG_TX_TIMEOUT:      tx_timeout      <= cfg_data;
        dprm_pkg::CFG_RESEND_INTERVAL: resend_interval <= cfg_data;
        dprm_pkg::CFG_RETRY_INTERVAL:  retry_interval  <= cfg_data;
        dprm_pkg::CFG_RETRY_LIMIT:     retry_limit     <= cfg_data[3:0];
        dprm_pkg::CFG_READ_COMMAND:    read_command    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_frame_valid <= frame_valid;
      in_frame_cmd   <= frame_cmd;
      in_frame_addr  <= frame_addr;
      in_tx_done     <= tx_done;
    end
  end

  // one tick: receive, transmit, then poll
  always_comb begin
    last_reply_next      = last_reply;
    target_next          = target;
    request_pending_next = request_pending;
    tx_busy_next         = tx_busy;
    tx_timer_next        = tx_timer;
    resend_timer_next    = resend_timer;
    retry_timer_next     = retry_timer;
    retry_count_next     = retry_count;
    delay_counter_next   = delay_counter;
    sent                 = 1'b0;
    sent_addr            = 3'd0;
    done                 = 1'b0;
    fire_resend          = 1'b0;
    fire_retry           = 1'b0;
    skip                 = 1'b0;

    if (in_frame_valid && in_frame_cmd == read_command) begin
      last_reply_next = in_frame_addr;
    end

    if (request_pending) begin
      tx_busy_next         = 1'b1;
      request_pending_next = 1'b0;
      sent                 = 1'b1;
      sent_addr            = target;
    end
    if (tx_busy_next) begin
      tx_timer_next = dprm_pkg::sat_inc16(tx_timer);
      if (tx_timer > tx_timeout || in_tx_done) begin
        tx_busy_next  = 1'b0;
        tx_timer_next = 16'd0;
      end
    end

    delay_counter_next = dprm_pkg::sat_inc16(delay_counter);
    if (delay_counter > poll_delay) begin
      unique case (last_reply_next)
        8'h00:              target_next = dprm_pkg::DRAWER_A[2:0];
        dprm_pkg::DRAWER_A: target_next = dprm_pkg::DRAWER_B[2:0];
        dprm_pkg::DRAWER_B: target_next = dprm_pkg::DRAWER_C[2:0];
        dprm_pkg::DRAWER_C: target_next = dprm_pkg::DRAWER_D[2:0];
        dprm_pkg::DRAWER_D: begin
          delay_counter_next = 16'd0;
          target_next        = 3'd0;
          last_reply_next    = 8'h00;
          done               = 1'b1;
        end
        default: begin
          // foreign address: restart the round position without ending it
          target_next     = 3'd0;
          last_reply_next = 8'h00;
        end
      endcase

      if (delay_counter_next >= poll_delay) begin
        fire_resend       = resend_timer > resend_interval;
        resend_timer_next = dprm_pkg::sat_inc16(resend_timer);
        if (fire_resend) begin
          tx_busy_next         = 1'b0;
          request_pending_next = 1'b1;
          resend_timer_next    = 16'd0;
          retry_timer_next     = 16'd0;
        end
        if (last_reply_next != {5'd0, target_next}) begin
          if (retry_count == 4'd0) begin
            retry_count_next     = 4'd1;
            retry_timer_next     = 16'd0;
            resend_timer_next    = 16'd0;
            request_pending_next = 1'b1;
          end
          fire_retry       = retry_timer_next > retry_interval;
          retry_timer_next = dprm_pkg::sat_inc16(retry_timer_next);
          if (fire_retry) begin
            skip                 = retry_count_next >= retry_limit;
            retry_timer_next     = 16'd0;
            resend_timer_next    = 16'd0;
            request_pending_next = 1'b1;
            if (retry_count_next < dprm_pkg::RETRY_COUNT_MAX) begin
              retry_count_next = retry_count_next + 4'd1;
            end
            if (skip) begin
              tx_busy_next     = 1'b0;
              tx_timer_next    = 16'd0;
              retry_count_next = 4'd0;
              last_reply_next  = {5'd0, target_next};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_reply      <= 8'h00;
      target          <= 3'd0;
      request_pending <= 1'b0;
      tx_busy         <= 1'b0;
      tx_timer        <= 16'd0;
      resend_timer    <= 16'd0;
      retry_timer     <= 16'd0;
      retry_count     <= 4'd0;
      delay_counter   <= 16'd0;
    end else if (advance) begin
      last_reply      <= last_reply_next;
      target          <= target_next;
      request_pending <= request_pending_next;
      tx_busy         <= tx_busy_next;
      tx_timer        <= tx_timer_next;
      resend_timer    <= resend_timer_next;
      retry_timer     <= retry_timer_next;
      retry_count     <= retry_count_next;
      delay_counter   <= delay_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      send_request  <= sent;
      request_addr  <= sent_addr;
      driver_enable <= tx_busy_next || request_pending_next;
      reply_addr    <= last_reply_next;
      round_done    <= done;
    end
  end

  `DPRM_ASSERT_NOW(a_target_on_map, clk, rst, 1'b1,
    target == 3'd0 || target == 3'd1 || target == 3'd3 || target == 3'd5 || target == 3'd7)
  `DPRM_ASSERT_NOW(a_idle_addr_zero, clk, rst, out_valid && !send_request, request_addr == 3'd0)
  `DPRM_ASSERT_NOW(a_round_resets_reply, clk, rst, out_valid && round_done, reply_addr == 8'h00)
  `DPRM_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `DPRM_ASSERT_NEXT(a_held_result, clk, rst, out_valid && !out_ready, out_valid)

endmodule
